>>> sv/cvr_pkg.sv
// Shared constants, types and codes for the replicate-border 2D convolution block.
package cvr_pkg;

   // Kernel geometry
   localparam int KS        = 11;
   localparam int HALF_K    = (KS - 1) / 2;
   localparam int TAP_COUNT = KS * KS;
   localparam int TAP_IDX_W = 7;
   localparam int K_W       = $clog2(KS);

   // Frame geometry
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int LINE_ROWS  = 12;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int CFG_W_W    = 11;
   localparam int CFG_H_W    = 13;

   // Row ring rounded up to a power of two so the slot is the low row bits
   localparam int RING_W    = $clog2(LINE_ROWS);
   localparam int RING_ROWS = 1 << RING_W;
   localparam int MEM_AW    = RING_W + COL_W;

   // Datapath widths
   localparam int PIX_W  = 8;
   localparam int TAP_W  = 16;
   localparam int PROD_W = PIX_W + TAP_W + 1;
   localparam int ACC_W  = 32;
   localparam int OUT_W  = 16;
   localparam int RND_SH = 7;

   // Item kinds
   localparam logic [1:0] KIND_TAP   = 2'd0;
   localparam logic [1:0] KIND_PIXEL = 2'd1;
   localparam logic [1:0] KIND_DRAIN = 2'd2;

   // Control of the tap chain
   typedef struct packed {
      logic                        shift;
      logic                        wr_en;
      logic [TAP_IDX_W-1:0]        wr_idx;
      logic signed [TAP_W-1:0]     wr_val;
   } tap_ctl_type;

endpackage

>>> sv/cvr_tap_cell.sv
// One kernel tap cell: holds a coefficient, loads on write, passes it on in a rotation.
module cvr_tap_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 shift,
   input  logic                                 wr_sel,
   input  logic signed [cvr_pkg::TAP_W-1:0]     wr_val,
   input  logic signed [cvr_pkg::TAP_W-1:0]     next_tap,
   output logic signed [cvr_pkg::TAP_W-1:0]     tap
);

   logic signed [cvr_pkg::TAP_W-1:0] tap_ff, tap_in;

   // rotation wins; writes only come while the chain is parked
   always_comb begin
      tap_in = tap_ff;
      if (shift) begin
         tap_in = next_tap;
      end else if (wr_sel) begin
         tap_in = wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
      end else begin
         tap_ff <= tap_in;
      end
   end

   assign tap = tap_ff;

endmodule

>>> sv/cvr_tap_chain.sv
// Ring of kernel tap cells; cell 0 is the head fed to the multiplier.
module cvr_tap_chain (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cvr_pkg::tap_ctl_type                 ctl,
   output logic signed [cvr_pkg::TAP_W-1:0]     head_tap
);

   logic signed [cvr_pkg::TAP_W-1:0] taps [cvr_pkg::TAP_COUNT];

   // each cell takes its upper neighbor; the last wraps to the head
   for (genvar i = 0; i < cvr_pkg::TAP_COUNT; i++) begin : g_cell
      logic wr_sel;
      assign wr_sel = ctl.wr_en && (ctl.wr_idx == cvr_pkg::TAP_IDX_W'(i));
      cvr_tap_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (ctl.shift),
         .wr_sel   (wr_sel),
         .wr_val   (ctl.wr_val),
         .next_tap (taps[(i + 1) % cvr_pkg::TAP_COUNT]),
         .tap      (taps[i])
      );
   end

   assign head_tap = taps[0];

endmodule

>>> sv/convolution_2d_replicate_border.sv
// Pixel transfers: a window check, then for a result 121 MAC steps, a pipeline flush and finish.
// The 121 steps walk the tap ring, one line-store read and one multiply per cycle.
// Tap writes and ignored kinds stay in the idle state. One item in flight; a finished result
// waits in the output register while the next item is taken.
// Synchronous reset: taps zero, frame position zero, size registers 1024 x 1024.
// The line store is not cleared; it holds no data until pixels are written.
module convolution_2d_replicate_border (
   input  logic                                     clock,
   input  logic                                     reset,
   // item channel
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [1:0]                               req_kind,
   input  logic [cvr_pkg::TAP_IDX_W-1:0]            req_tap_index,
   input  logic signed [cvr_pkg::TAP_W-1:0]         req_tap_value,
   input  logic [cvr_pkg::PIX_W-1:0]                req_pixel,
   // result channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [cvr_pkg::OUT_W-1:0]                rsp_filtered,
   output logic                                     rsp_clipped,
   output logic                                     rsp_frame_end,
   // register port
   input  logic                                     psel,
   input  logic                                     penable,
   input  logic                                     pwrite,
   input  logic [2:0]                               paddr,
   input  logic [31:0]                              pwdata,
   output logic [31:0]                              prdata,
   output logic                                     pready
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_CALC   = 5'b00100,
      ST_FLUSH  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [cvr_pkg::CFG_W_W-1:0] width_ff, width_in;
   logic [cvr_pkg::CFG_H_W-1:0] height_ff, height_in;
   logic [cvr_pkg::ROW_W-1:0]   in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [cvr_pkg::COL_W-1:0]   in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic                        done_ff, done_in;
   logic [cvr_pkg::K_W-1:0]     m_ff, m_in, n_ff, n_in;
   logic                        v1_ff, v2_ff;
   logic signed [cvr_pkg::TAP_W-1:0]  tap1_ff, head_tap;
   logic [cvr_pkg::PIX_W-1:0]         rd_ff;
   logic signed [cvr_pkg::PROD_W-1:0] prod_ff;
   logic signed [cvr_pkg::ACC_W-1:0]  acc_ff;
   logic                        rsp_valid_ff;
   logic [cvr_pkg::OUT_W-1:0]   filtered_ff;
   logic                        clipped_ff, frame_end_ff;

   logic                        req_xfer, cfg_wr, pix_xfer, tap_xfer, issue, load_rsp;
   logic [cvr_pkg::COL_W-1:0]   wm1;
   logic [cvr_pkg::ROW_W-1:0]   hm1;
   logic                        pos_restart, last_pos, frame_end_calc, ready;
   logic [cvr_pkg::ROW_W-1:0]   row_cur;
   logic [cvr_pkg::COL_W-1:0]   col_cur;
   logic [cvr_pkg::ROW_W:0]     nr;
   logic [cvr_pkg::COL_W:0]     nc;
   logic signed [cvr_pkg::ROW_W+1:0] ys;
   logic signed [cvr_pkg::COL_W+1:0] xs;
   logic [cvr_pkg::ROW_W-1:0]   y_cl;
   logic [cvr_pkg::COL_W-1:0]   x_cl;
   logic [cvr_pkg::MEM_AW-1:0]  rd_addr, wr_addr;
   logic signed [cvr_pkg::ACC_W-1:0] q;
   logic [cvr_pkg::ACC_W-1:0]   r;
   logic [cvr_pkg::OUT_W-1:0]   res_val;
   logic                        res_clip;
   cvr_pkg::tap_ctl_type        tap_ctl;

   logic [cvr_pkg::PIX_W-1:0] line_mem [cvr_pkg::RING_ROWS * cvr_pkg::MAX_WIDTH];

   // handshakes; a register write holds off the item channel for that cycle
   assign cfg_wr    = psel && penable && pwrite;
   assign req_stall = (state_ff != ST_IDLE) || cfg_wr;
   assign req_xfer  = req_valid && !req_stall;
   assign pix_xfer  = req_xfer && (req_kind == cvr_pkg::KIND_PIXEL);
   assign tap_xfer  = req_xfer && (req_kind == cvr_pkg::KIND_TAP);
   assign pready    = 1'b1;
   assign issue     = (state_ff == ST_CALC);
   assign load_rsp  = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // register read
   always_comb begin
      prdata = '0;
      if (paddr[2]) begin
         prdata[cvr_pkg::CFG_H_W-1:0] = height_ff;
      end else begin
         prdata[cvr_pkg::CFG_W_W-1:0] = width_ff;
      end
   end

   // sizes in use, minus one
   always_comb begin
      if (width_ff == '0) begin
         wm1 = '0;
      end else if (width_ff > cvr_pkg::CFG_W_W'(cvr_pkg::MAX_WIDTH)) begin
         wm1 = cvr_pkg::COL_W'(cvr_pkg::MAX_WIDTH - 1);
      end else begin
         wm1 = cvr_pkg::COL_W'(width_ff - 1'b1);
      end
      if (height_ff == '0) begin
         hm1 = '0;
      end else if (height_ff > cvr_pkg::CFG_H_W'(cvr_pkg::MAX_HEIGHT)) begin
         hm1 = cvr_pkg::ROW_W'(cvr_pkg::MAX_HEIGHT - 1);
      end else begin
         hm1 = cvr_pkg::ROW_W'(height_ff - 1'b1);
      end
   end

   // write position of an incoming pixel
   assign pos_restart = done_ff || (in_row_ff > hm1) || (in_col_ff > wm1);
   assign row_cur     = pos_restart ? '0 : in_row_ff;
   assign col_cur     = pos_restart ? '0 : in_col_ff;
   assign wr_addr     = {row_cur[cvr_pkg::RING_W-1:0], col_cur};

   // window complete check
   always_comb begin
      nr = {1'b0, out_row_ff} + (cvr_pkg::ROW_W+1)'(cvr_pkg::HALF_K);
      if (nr > {1'b0, hm1}) begin
         nr = {1'b0, hm1};
      end
      nc = {1'b0, out_col_ff} + (cvr_pkg::COL_W+1)'(cvr_pkg::HALF_K);
      if (nc > {1'b0, wm1}) begin
         nc = {1'b0, wm1};
      end
      ready = done_ff || (nr < {1'b0, in_row_ff})
              || ((nr == {1'b0, in_row_ff}) && (nc < {1'b0, in_col_ff}));
   end

   // tap address with replicated border
   always_comb begin
      ys = $signed({2'b00, out_row_ff}) + $signed({{(cvr_pkg::ROW_W-cvr_pkg::K_W+2){1'b0}}, m_ff})
           - (cvr_pkg::ROW_W+2)'(cvr_pkg::HALF_K);
      xs = $signed({2'b00, out_col_ff}) + $signed({{(cvr_pkg::COL_W-cvr_pkg::K_W+2){1'b0}}, n_ff})
           - (cvr_pkg::COL_W+2)'(cvr_pkg::HALF_K);
      if (ys < 0) begin
         y_cl = '0;
      end else if (ys > $signed({2'b00, hm1})) begin
         y_cl = hm1;
      end else begin
         y_cl = ys[cvr_pkg::ROW_W-1:0];
      end
      if (xs < 0) begin
         x_cl = '0;
      end else if (xs > $signed({2'b00, wm1})) begin
         x_cl = wm1;
      end else begin
         x_cl = xs[cvr_pkg::COL_W-1:0];
      end
      rd_addr = {y_cl[cvr_pkg::RING_W-1:0], x_cl};
   end

   // tap ring control
   always_comb begin
      tap_ctl.shift  = issue;
      tap_ctl.wr_en  = tap_xfer && (req_tap_index < cvr_pkg::TAP_IDX_W'(cvr_pkg::TAP_COUNT));
      tap_ctl.wr_idx = req_tap_index;
      tap_ctl.wr_val = req_tap_value;
   end

   cvr_tap_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .ctl      (tap_ctl),
      .head_tap (head_tap)
   );

   // line store
   always_ff @(posedge clock) begin
      if (pix_xfer) begin
         line_mem[wr_addr] <= req_pixel;
      end
      rd_ff <= line_mem[rd_addr];
   end

   // multiply-accumulate pipeline
   always_ff @(posedge clock) begin
      tap1_ff <= head_tap;
      prod_ff <= $signed({1'b0, rd_ff}) * tap1_ff;
      if (state_ff == ST_CHECK) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + cvr_pkg::ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
      end
   end

   // round half up to Q8.8 and clip
   always_comb begin
      q        = acc_ff + cvr_pkg::ACC_W'(64);
      r        = cvr_pkg::ACC_W'(q >>> cvr_pkg::RND_SH);
      res_val  = r[cvr_pkg::OUT_W-1:0];
      res_clip = 1'b0;
      if (q < 0) begin
         res_val  = '0;
         res_clip = 1'b1;
      end else if (r > cvr_pkg::ACC_W'(16'hFFFF)) begin
         res_val  = '1;
         res_clip = 1'b1;
      end
   end

   assign last_pos       = (out_row_ff == hm1) && (out_col_ff == wm1);
   assign frame_end_calc = last_pos;

   // sequencer and frame position
   always_comb begin
      state_in   = state_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      done_in    = done_ff;
      m_in       = m_ff;
      n_in       = n_ff;
      case (state_ff)
         ST_IDLE: begin
            m_in = '0;
            n_in = '0;
            if (cfg_wr) begin
               if (paddr[2]) begin
                  height_in = pwdata[cvr_pkg::CFG_H_W-1:0];
               end else begin
                  width_in = pwdata[cvr_pkg::CFG_W_W-1:0];
               end
               in_row_in  = '0;
               in_col_in  = '0;
               out_row_in = '0;
               out_col_in = '0;
               done_in    = 1'b0;
            end else if (req_xfer) begin
               if (req_kind == cvr_pkg::KIND_PIXEL) begin
                  if (pos_restart) begin
                     out_row_in = '0;
                     out_col_in = '0;
                     done_in    = 1'b0;
                  end
                  if (col_cur == wm1) begin
                     in_col_in = '0;
                     if (row_cur == hm1) begin
                        in_row_in = '0;
                        done_in   = 1'b1;
                     end else begin
                        in_row_in = row_cur + 1'b1;
                     end
                  end else begin
                     in_col_in = col_cur + 1'b1;
                     in_row_in = row_cur;
                  end
                  state_in = ST_CHECK;
               end else if (req_kind == cvr_pkg::KIND_DRAIN) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            state_in = ready ? ST_CALC : ST_IDLE;
         end
         ST_CALC: begin
            if (n_ff == cvr_pkg::K_W'(cvr_pkg::KS - 1)) begin
               n_in = '0;
               if (m_ff == cvr_pkg::K_W'(cvr_pkg::KS - 1)) begin
                  m_in     = '0;
                  state_in = ST_FLUSH;
               end else begin
                  m_in = m_ff + 1'b1;
               end
            end else begin
               n_in = n_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            if (!v1_ff && !v2_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
               if (last_pos) begin
                  in_row_in  = '0;
                  in_col_in  = '0;
                  out_row_in = '0;
                  out_col_in = '0;
                  done_in    = 1'b0;
               end else if (out_col_ff == wm1) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + 1'b1;
               end else begin
                  out_col_in = out_col_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         width_ff   <= cvr_pkg::CFG_W_W'(cvr_pkg::MAX_WIDTH);
         height_ff  <= cvr_pkg::CFG_H_W'(1024);
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         done_ff    <= 1'b0;
         m_ff       <= '0;
         n_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         done_ff    <= done_in;
         m_ff       <= m_in;
         n_ff       <= n_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         filtered_ff  <= res_val;
         clipped_ff   <= res_clip;
         frame_end_ff <= frame_end_calc;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = filtered_ff;
   assign rsp_clipped   = clipped_ff;
   assign rsp_frame_end = frame_end_ff;

`ifndef NO_ASSERTIONS
   // the walk covers every tap before the pipeline flush
   a_full_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && $past(state_ff) == ST_CALC)
      |-> ($past(m_ff) == cvr_pkg::K_W'(cvr_pkg::KS - 1)
           && $past(n_ff) == cvr_pkg::K_W'(cvr_pkg::KS - 1)))
      else $error("tap walk ended early");

   // the sum is complete before it is rounded
   a_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (!v1_ff && !v2_ff))
      else $error("accumulator still busy at finish");

   // a clipped result sits at a rail
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && clipped_ff) |-> (filtered_ff == '0 || filtered_ff == '1))
      else $error("clipped result off the rail");

   // last pixel of a frame restarts the position
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && frame_end_calc)
      |=> (out_row_ff == '0 && out_col_ff == '0 && in_row_ff == '0 && !done_ff))
      else $error("frame position not restarted");
`endif

endmodule

>>> sim/tb_convolution_2d_replicate_border.sv
// Self-checking testbench for the replicate-border 2D convolution block.
module tb_convolution_2d_replicate_border;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [2:0] ADDR_WIDTH  = 3'd0;
   localparam logic [2:0] ADDR_HEIGHT = 3'd4;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE      = 160;

   typedef struct {
      logic [1:0]        kind;
      logic [6:0]        tap_idx;
      logic [15:0]       tap_val;
      logic [7:0]        pix;
   } item_type;

   typedef struct {
      logic [15:0] filtered;
      logic        clipped;
      logic        frame_end;
   } filt_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [1:0] req_kind;
   logic [cvr_pkg::TAP_IDX_W-1:0] req_tap_index;
   logic signed [cvr_pkg::TAP_W-1:0] req_tap_value;
   logic [cvr_pkg::PIX_W-1:0] req_pixel;
   logic rsp_valid, rsp_stall;
   logic [cvr_pkg::OUT_W-1:0] rsp_filtered;
   logic rsp_clipped, rsp_frame_end;
   logic psel, penable, pwrite, pready;
   logic [2:0] paddr;
   logic [31:0] pwdata, prdata;

   convolution_2d_replicate_border u_top (.*);

   // pending item transfers and expected filtered pixels
   item_type pending_items[$];
   filt_type expected_pixels[$];
   int    mismatches = 0;
   int    idle_pct = 0;
   bit    quiet = 0;
   int    cycles = 0;
   int    pushed = 0;

   // shadow of the block state
   int               width_reg, height_reg;
   logic [7:0]       line_mem [cvr_pkg::LINE_ROWS*cvr_pkg::MAX_WIDTH];
   logic signed [15:0] taps [cvr_pkg::TAP_COUNT];
   int               in_r, in_c, out_r, out_c;
   bit               frame_in_done;

   function automatic int used_w();
      return (width_reg < 1) ? 1 :
             (width_reg > cvr_pkg::MAX_WIDTH) ? cvr_pkg::MAX_WIDTH : width_reg;
   endfunction

   function automatic int used_h();
      return (height_reg < 1) ? 1 :
             (height_reg > cvr_pkg::MAX_HEIGHT) ? cvr_pkg::MAX_HEIGHT : height_reg;
   endfunction

   function automatic void restart_position();
      in_r = 0; in_c = 0; out_r = 0; out_c = 0;
      frame_in_done = 0;
   endfunction

   // produce the next output pixel if its whole window has arrived
   function automatic void emit_pixel(int w, int h);
      int nr, nc, y, x;
      longint acc, q;
      filt_type res;
      nr = (out_r + cvr_pkg::HALF_K > h - 1) ? h - 1 : out_r + cvr_pkg::HALF_K;
      nc = (out_c + cvr_pkg::HALF_K > w - 1) ? w - 1 : out_c + cvr_pkg::HALF_K;
      if (!frame_in_done && !(nr < in_r || (nr == in_r && nc < in_c))) return;
      acc = 0;
      for (int m = 0; m < cvr_pkg::KS; m++)
         for (int n = 0; n < cvr_pkg::KS; n++) begin
            y = out_r + m - cvr_pkg::HALF_K;
            x = out_c + n - cvr_pkg::HALF_K;
            y = (y < 0) ? 0 : (y > h - 1) ? h - 1 : y;
            x = (x < 0) ? 0 : (x > w - 1) ? w - 1 : x;
            acc += longint'(line_mem[(y % cvr_pkg::LINE_ROWS)*cvr_pkg::MAX_WIDTH + x])
                   * taps[m*cvr_pkg::KS + n];
         end
      q = acc + 64;
      res.clipped = 0;
      if (q < 0) begin
         res.filtered = '0; res.clipped = 1;
      end else if ((q >>> 7) > 65535) begin
         res.filtered = 16'hFFFF; res.clipped = 1;
      end else begin
         res.filtered = 16'(q >>> 7);
      end
      res.frame_end = 0;
      if (out_r == h - 1 && out_c == w - 1) begin
         res.frame_end = 1;
         restart_position();
      end else if (out_c + 1 >= w) begin
         out_c = 0; out_r++;
      end else begin
         out_c++;
      end
      expected_pixels.push_back(res);
   endfunction

   // update the shadow for one accepted item
   function automatic void predict_item(item_type it);
      int w, h;
      w = used_w(); h = used_h();
      case (it.kind)
         cvr_pkg::KIND_TAP: begin
            if (it.tap_idx < cvr_pkg::TAP_COUNT) taps[it.tap_idx] = it.tap_val;
         end
         cvr_pkg::KIND_PIXEL: begin
            if (frame_in_done || in_r > h - 1 || in_c > w - 1) restart_position();
            line_mem[(in_r % cvr_pkg::LINE_ROWS)*cvr_pkg::MAX_WIDTH + in_c] = it.pix;
            if (in_c + 1 >= w) begin
               in_c = 0;
               if (in_r + 1 >= h) begin
                  in_r = 0; frame_in_done = 1;
               end else begin
                  in_r++;
               end
            end else begin
               in_c++;
            end
            emit_pixel(w, h);
         end
         cvr_pkg::KIND_DRAIN: emit_pixel(w, h);
         default: ;
      endcase
   endfunction

   // clock
   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_convolution_2d_replicate_border failed");
         $finish;
      end
   end

   // driver: feeds item transfers from the pending queue
   int drv_gap = 0;
   always @(posedge clock) begin
      item_type it;
      bit    load;
      if (reset) begin
         req_valid <= 0;
         req_kind <= cvr_pkg::KIND_TAP;
         req_tap_index <= '0;
         req_tap_value <= '0;
         req_pixel <= '0;
      end else begin
         if (req_valid && !req_stall)
            predict_item('{req_kind, req_tap_index, req_tap_value, req_pixel});
         if (!req_valid || !req_stall) begin
            load = 0;
            if (drv_gap > 0) begin
               drv_gap--;
            end else if (!quiet && idle_pct > 0 && $urandom_range(99) < idle_pct) begin
               drv_gap = $urandom_range(0, 4);
            end else if (pending_items.size() > 0) begin
               it = pending_items.pop_front();
               load = 1;
               req_kind <= it.kind;
               req_tap_index <= it.tap_idx;
               req_tap_value <= it.tap_val;
               req_pixel <= it.pix;
            end
            req_valid <= load;
         end
      end
   end

   // monitor: random stall, checks each result transfer
   int mon_gap = 0;
   always @(posedge clock) begin
      filt_type e;
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: filtered %0d clipped %0d frame_end %0d",
                           rsp_filtered, rsp_clipped, rsp_frame_end);
            end else begin
               e = expected_pixels.pop_front();
               if (rsp_filtered !== e.filtered || rsp_clipped !== e.clipped ||
                   rsp_frame_end !== e.frame_end) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                              e.filtered, e.clipped, e.frame_end,
                              rsp_filtered, rsp_clipped, rsp_frame_end);
               end
            end
         end
         if (mon_gap > 0) begin
            mon_gap--;
            rsp_stall <= 1;
         end else if (!quiet && idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            mon_gap = $urandom_range(0, 4);
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   task automatic push(logic [1:0] kind, logic [6:0] idx, logic [15:0] val, logic [7:0] pix);
      item_type it;
      it = '{kind, idx, val, pix};
      pending_items.push_back(it);
      pushed++;
   endtask

   function automatic logic [6:0] rnd_idx();
      return 7'($urandom_range(0, 127));
   endfunction

   task automatic push_pixels(int n);
      for (int i = 0; i < n; i++)
         push(cvr_pkg::KIND_PIXEL, rnd_idx(), 16'($urandom), 8'($urandom));
   endtask

   task automatic push_drains(int n);
      for (int i = 0; i < n; i++)
         push(cvr_pkg::KIND_DRAIN, rnd_idx(), 16'($urandom), 8'($urandom));
   endtask

   // wait until every transfer is done and the block has settled
   task automatic wait_idle();
      while (pending_items.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // register write: setup cycle then access cycle
   task automatic csr_write(logic [2:0] addr, int value);
      @(posedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      if (addr == ADDR_WIDTH) width_reg = value & 32'h7FF;
      else height_reg = value & 32'h1FFF;
      restart_position();
   endtask

   task automatic set_size(int w, int h);
      wait_idle();
      csr_write(ADDR_WIDTH, w);
      csr_write(ADDR_HEIGHT, h);
   endtask

   // whole frame followed by enough drains to flush it
   task automatic push_frame(int w, int h);
      push_pixels(w * h);
      push_drains(((w * h < 6 * w + 6) ? w * h : 6 * w + 6) + 2);
   endtask

   // new kernel in one of a few styles
   task automatic push_kernel();
      int style;
      logic [15:0] v;
      style = $urandom_range(0, 3);
      for (int t = 0; t < cvr_pkg::TAP_COUNT; t++) begin
         case (style)
            0: v = 16'($urandom);
            1: v = 16'($signed($urandom_range(0, 1800)) - 600);
            2: v = (t == cvr_pkg::TAP_COUNT / 2) ? 16'h7FFF : 16'h0000;
            default: v = 16'($signed($urandom_range(0, 300)));
         endcase
         push(cvr_pkg::KIND_TAP, 7'(t), v, 8'($urandom));
      end
      // stray index past the kernel is dropped
      push(cvr_pkg::KIND_TAP, 7'($urandom_range(cvr_pkg::TAP_COUNT, 127)), 16'($urandom),
           8'($urandom));
   endtask

   initial begin
      int w, h;
      reset = 1;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      width_reg = 1024; height_reg = 1024;
      foreach (taps[i]) taps[i] = '0;
      foreach (line_mem[i]) line_mem[i] = '0;
      restart_position();
      repeat (3) @(posedge clock);
      reset <= 0;

      // directed: reset size, extreme taps and pixels, odd kinds
      push(cvr_pkg::KIND_TAP, 7'(cvr_pkg::TAP_COUNT / 2), 16'h7FFF, 8'h00);
      push(cvr_pkg::KIND_TAP, 7'd0, 16'h8000, 8'hFF);
      push(cvr_pkg::KIND_TAP, 7'd127, 16'h1234, 8'h00);
      push(KIND_UNUSED, 7'd5, 16'hFFFF, 8'hFF);
      push(cvr_pkg::KIND_DRAIN, 7'd0, 16'h0, 8'h0);
      push(cvr_pkg::KIND_PIXEL, 7'd0, 16'h0, 8'h00);
      push(cvr_pkg::KIND_PIXEL, 7'd0, 16'h0, 8'hFF);
      set_size(4, 3);
      push(cvr_pkg::KIND_PIXEL, 7'd0, 16'h0, 8'hFF);
      push(cvr_pkg::KIND_PIXEL, 7'd0, 16'h0, 8'h00);
      push_pixels(6);
      // tap change in the middle of a frame
      push(cvr_pkg::KIND_TAP, 7'd60, 16'h4000, 8'h0);
      push_pixels(4);
      push_drains(2);
      // new pixel drops the outputs still pending
      push_pixels(3);
      set_size(0, 0);
      push_pixels(2);
      push_drains(1);

      // random frames, most well-formed
      idle_pct = 20;
      while (pushed < 800) begin
         if ($urandom_range(0, 3) == 0) idle_pct = 0;
         else idle_pct = $urandom_range(10, 40);
         if (pushed > 650) quiet = 1;
         case ($urandom_range(0, 9))
            0: begin
               set_size(2047, 8191);
               push_pixels($urandom_range(10, 40));
               push_drains(3);
            end
            1: begin
               set_size(1024, 4096);
               push_pixels($urandom_range(5, 20));
            end
            2: begin
               // noise: odd kinds, empty drains, stray taps, partial frame
               for (int i = 0; i < 12; i++)
                  push(2'($urandom_range(0, 3)), rnd_idx(), 16'($urandom), 8'($urandom));
            end
            default: begin
               w = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 14);
               h = $urandom_range(1, 14);
               if (w * h > 200) h = 200 / w + 1;
               set_size(w, h);
               if ($urandom_range(0, 2) == 0) push_kernel();
               push_frame(w, h);
            end
         endcase
      end

      wait_idle();
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("tb_convolution_2d_replicate_border passed");
      end else begin
         $display("tb_convolution_2d_replicate_border failed");
      end
      $finish;
   end
endmodule
